FILE: rtl/ohash_pkg.sv
`default_nettype none

package ohash_pkg;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // result field widths
   localparam int INDEX_OUT_W = 10;
   localparam int OCC_OUT_W   = 11;

   // configuration registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG2     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OCCUPANCY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE    = 2'd2;

   localparam int SIZE_LOG2_W = 4;
   localparam int MAX_OCC_W   = 10;
   localparam int MIN_LOG2    = 3;

   localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RST = 4'd10;
   localparam logic [MAX_OCC_W-1:0]   MAX_OCC_RST   = 10'd886;
   localparam logic                   PROBE_MODE_RST = 1'b0;

   localparam logic PROBE_XOR    = 1'b0;
   localparam logic PROBE_LINEAR = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic read;
      logic advance;
      logic finish;
   } ohash_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic probe_stop;
      logic out_free;
   } ohash_sts_type;

endpackage

`default_nettype wire

FILE: rtl/ohash_ctrl.sv
`default_nettype none

module ohash_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  ohash_pkg::ohash_sts_type sts,
   output ohash_pkg::ohash_cmd_type cmd
);
   import ohash_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_CMP   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            // once the probe stops, hold here while the result register is still occupied
            if (sts.probe_stop) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ohash_dpath.sv
`default_nettype none

module ohash_dpath #(
   parameter int MAX_BUCKETS = 1024,
   parameter int HASH_BITS   = 32,
   parameter int KEY_BITS    = 64
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   input  wire  [ohash_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [ohash_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire                                   req_func,
   input  wire  [HASH_BITS-1:0]                  req_hash_value,
   input  wire  [KEY_BITS-1:0]                   req_key_value,
   input  wire                                   rsp_ready,
   input  ohash_pkg::ohash_cmd_type              cmd,
   output ohash_pkg::ohash_sts_type              sts,
   output logic                                  rsp_valid,
   output logic [ohash_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ohash_pkg::INDEX_OUT_W-1:0]     rsp_bucket_index,
   output logic [ohash_pkg::OCC_OUT_W-1:0]       rsp_occupancy
);
   import ohash_pkg::*;

   localparam int IDX_W   = $clog2(MAX_BUCKETS);
   localparam int CNT_W   = $clog2(MAX_BUCKETS + 1);
   localparam int LOG_MAX = CNT_W - 1;
   localparam int LG_W    = 5;
   localparam int WORD_W  = 1 + HASH_BITS + KEY_BITS;
   localparam int CMP_W   = CNT_W + MAX_OCC_W;

   // configuration
   logic [SIZE_LOG2_W-1:0] size_log2_ff, size_log2_in;
   logic [MAX_OCC_W-1:0]   max_occ_ff, max_occ_in;
   logic                   probe_mode_ff, probe_mode_in;

   // operation in flight
   logic                   func_ff, func_in;
   logic [HASH_BITS-1:0]   hash_ff, hash_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]       start_ff, start_in;
   logic [IDX_W-1:0]       x_ff, x_in;
   logic [WORD_W-1:0]      rd_word_ff;

   logic [IDX_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [OCC_OUT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   // bucket word: valid, hash, key
   logic [WORD_W-1:0]      bucket_mem [MAX_BUCKETS];

   logic [LG_W-1:0]        lg;
   logic [IDX_W-1:0]       mask;
   logic [IDX_W-1:0]       probe_addr;
   logic                   rd_valid;
   logic                   hit;
   logic                   last_probe;
   logic                   count_full;
   logic                   do_insert;
   logic [STATUS_W-1:0]    res_status;
   logic [IDX_W-1:0]       res_index;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [WORD_W-1:0]      mem_wdata;

   // clamp the size to the supported range and build the index mask
   always_comb begin
      lg = LG_W'(size_log2_ff);
      if (lg < LG_W'(MIN_LOG2)) begin
         lg = LG_W'(MIN_LOG2);
      end
      if (lg > LG_W'(LOG_MAX)) begin
         lg = LG_W'(LOG_MAX);
      end
      for (int i = 0; i < IDX_W; i++) begin
         mask[i] = (LG_W'(i) < lg);
      end
   end

   always_comb begin
      if (probe_mode_ff == PROBE_LINEAR) begin
         probe_addr = (start_ff + x_ff) & mask;
      end else begin
         probe_addr = (start_ff ^ x_ff) & mask;
      end
   end

   assign rd_valid   = rd_word_ff[WORD_W-1];
   assign hit        = rd_valid && (rd_word_ff[KEY_BITS +: HASH_BITS] == hash_ff)
                       && (rd_word_ff[KEY_BITS-1:0] == key_ff);
   assign last_probe = (x_ff == mask);
   assign count_full = CMP_W'(count_ff) >= CMP_W'(max_occ_ff);

   always_comb begin
      do_insert  = 1'b0;
      res_status = ST_FOUND;
      res_index  = probe_addr;
      if (hit) begin
         res_status = ST_FOUND;
      end else if (func_ff == FUNC_LOOKUP) begin
         res_status = ST_NOT_FOUND;
         if (rd_valid) begin
            res_index = '0;
         end
      end else if (rd_valid || count_full) begin
         res_status = ST_FULL;
         res_index  = '0;
      end else begin
         res_status = ST_INSERTED;
         do_insert  = 1'b1;
      end
   end

   assign sts.clear_last = (clr_addr_ff == IDX_W'(MAX_BUCKETS - 1));
   assign sts.probe_stop = !rd_valid || hit || last_probe;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = probe_addr;
      mem_wdata = {1'b1, hash_ff, key_ff};
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.finish && do_insert) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      size_log2_in  = size_log2_ff;
      max_occ_in    = max_occ_ff;
      probe_mode_in = probe_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SIZE_LOG2:     size_log2_in  = csr_wdata[SIZE_LOG2_W-1:0];
            CSR_MAX_OCCUPANCY: max_occ_in    = csr_wdata[MAX_OCC_W-1:0];
            CSR_PROBE_MODE:    probe_mode_in = csr_wdata[0];
            default:           ;
         endcase
      end

      func_in  = func_ff;
      hash_in  = hash_ff;
      key_in   = key_ff;
      start_in = start_ff;
      x_in     = x_ff;
      if (cmd.accept) begin
         func_in  = req_func;
         hash_in  = req_hash_value;
         key_in   = req_key_value;
         start_in = IDX_W'(req_hash_value) & mask;
         x_in     = '0;
      end else if (cmd.advance) begin
         x_in = x_ff + IDX_W'(1);
      end

      clr_addr_in = cmd.clear_step ? clr_addr_ff + IDX_W'(1) : clr_addr_ff;
      count_in    = (cmd.finish && do_insert) ? count_ff + CNT_W'(1) : count_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_index_in  = INDEX_OUT_W'(res_index);
         rsp_occ_in    = OCC_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff  <= SIZE_LOG2_RST;
         max_occ_ff    <= MAX_OCC_RST;
         probe_mode_ff <= PROBE_MODE_RST;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size_log2_ff  <= size_log2_in;
         max_occ_ff    <= max_occ_in;
         probe_mode_ff <= probe_mode_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      hash_ff       <= hash_in;
      key_ff        <= key_in;
      start_ff      <= start_in;
      x_ff          <= x_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_word_ff <= bucket_mem[probe_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

`default_nettype wire

FILE: rtl/open_address_hash_table_unit.sv
`default_nettype none

// Open-addressed hash table with insert and lookup.
// Request channel (req_): one operation per transfer with a precomputed hash
// and a key. Response channel (rsp_): status, bucket index and occupancy, one
// response per request, in order. Configuration channel (csr_): size_log2,
// max_occupancy and probe_mode; write only while no request is in flight.
// Each request probes from 1 bucket up to the bucket count in use. Each probe is
// a bucket memory read followed by a compare, through the single read port.
// A request transfers only in the idle state, after the previous one has
// finished probing, so requests do not overlap in the probe engine.
// A new request is taken once the previous one has been written to the
// response register, so a response may wait while the next probe runs.
// Reset: the bucket memory is swept clear, one bucket per cycle, over all
// MAX_BUCKETS buckets; req_ready stays low during the sweep. Configuration
// resets to size_log2 10, max_occupancy 886, linear probing off.
// When the receiver stalls, the finished result holds the probe engine until
// the response register drains.

module open_address_hash_table_unit #(
   parameter int MAX_BUCKETS = 1024,
   parameter int HASH_BITS   = 32,
   parameter int KEY_BITS    = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [ohash_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ohash_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_func,
   input  wire  [HASH_BITS-1:0]               req_hash_value,
   input  wire  [KEY_BITS-1:0]                req_key_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [ohash_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ohash_pkg::INDEX_OUT_W-1:0]  rsp_bucket_index,
   output logic [ohash_pkg::OCC_OUT_W-1:0]    rsp_occupancy
);
   import ohash_pkg::*;

   ohash_cmd_type cmd;
   ohash_sts_type sts;

   assign csr_ready = 1'b1;

   ohash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ohash_dpath #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .HASH_BITS   (HASH_BITS),
      .KEY_BITS    (KEY_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_hash_value   (req_hash_value),
      .req_key_value    (req_key_value),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_occupancy    (rsp_occupancy)
   );

   // a result is only committed when the response register can take it
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("finish issued while response register is busy");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.accept, cmd.read, cmd.advance, cmd.finish}))
      else $error("more than one controller command at once");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.read)
      else $error("request transfer not followed by a bucket read");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken before the clearing sweep");

endmodule

`default_nettype wire
